>>> src/htok_pkg.sv
package htok_pkg;

	// Token kinds carried on the result channel
	localparam logic [2:0] KIND_DROP     = 3'd0;
	localparam logic [2:0] KIND_METHOD   = 3'd1;
	localparam logic [2:0] KIND_URI      = 3'd2;
	localparam logic [2:0] KIND_VERSION  = 3'd3;
	localparam logic [2:0] KIND_HDR_NAME = 3'd4;
	localparam logic [2:0] KIND_HDR_VAL  = 3'd5;
	localparam logic [2:0] KIND_HDR_END  = 3'd6;
	localparam logic [2:0] KIND_BODY     = 3'd7;

	// Error codes, sticky until the end of the request
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_METHOD   = 2'd1;
	localparam logic [1:0] ERR_NO_COLON = 2'd2;

	// Method codes; UNKNOWN never leaves the block
	localparam logic [3:0] METH_GET     = 4'd0;
	localparam logic [3:0] METH_UNKNOWN = 4'd9;
	localparam int         METH_NUM     = 9;

	// Method token store: up to seven bytes, byte i at bits 8i+7:8i
	localparam int         METH_MAX_LEN = 7;
	localparam logic [3:0] METH_OVERLONG = 4'd8;

	// Bytes of interest
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;

	// Lengths of the method names
	localparam logic [3:0] METH_LENS [METH_NUM] = '{
		4'd3, 4'd3, 4'd4, 4'd4, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
	};

	// Packed method name by code, first byte lowest
	function automatic logic [55:0] meth_name(input logic [3:0] code);
		logic [55:0] name;
		begin
			unique case (code)
				4'd0:    name = 56'h00000000544547;   // GET
				4'd1:    name = 56'h00000000545550;   // PUT
				4'd2:    name = 56'h00000054534F50;   // POST
				4'd3:    name = 56'h00000044414548;   // HEAD
				4'd4:    name = 56'h004554454C4544;   // DELETE
				4'd5:    name = 56'h5443454E4E4F43;   // CONNECT
				4'd6:    name = 56'h534E4F4954504F;   // OPTIONS
				4'd7:    name = 56'h00004543415254;   // TRACE
				4'd8:    name = 56'h00004843544150;   // PATCH
				default: name = '0;
			endcase
			return name;
		end
	endfunction

	// Match the token against every name; UNKNOWN when none fits
	function automatic logic [3:0] meth_lookup(input logic [55:0] chars,
		input logic [3:0] count);
		logic [3:0] code;
		begin
			code = METH_UNKNOWN;
			for (int k = METH_NUM - 1; k >= 0; k--) begin
				if (METH_LENS[k] == count && meth_name(4'(k)) == chars)
					code = 4'(k);
			end
			return code;
		end
	endfunction

	// Whitespace as the tokenizer sees it
	function automatic logic is_ws(input logic [7:0] b);
		return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_VT ||
			b == CH_FF || b == CH_CR;
	endfunction

	// One result of the tokenizer
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] byte_out;
		logic [3:0] method_code;
		logic [1:0] error_code;
		logic       request_end;
	} htok_res_t;

endpackage

>>> src/htok_in_if.sv
interface htok_in_if (input logic clk);
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> src/htok_out_if.sv
interface htok_out_if (input logic clk);
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] byte_out;
	logic [3:0] method_code;
	logic [1:0] error_code;
	logic       request_end;

	modport source (output valid, output kind, output byte_out, output method_code,
		output error_code, output request_end, input ready);
	modport sink (input valid, input kind, input byte_out, input method_code,
		input error_code, input request_end, output ready);
endinterface

>>> src/http_request_tokenizer_core.sv
// Byte-stream HTTP request tokenizer. Each accepted request byte yields exactly
// one result in the following cycle, tagging it as method end, URI, version, header
// name, header value, header line end, body or dropped; the method is decoded
// to a code when its token ends, and a sticky error code flags an unknown
// method or a header line without a colon until the byte marked last, after
// which all state returns to its reset value. Throughput is one byte per
// cycle: the next tokenizer state is formed combinationally, and the only storage
// between input and output is the result register, which keeps accepting
// while the downstream side takes each result as it is offered.
module http_request_tokenizer_core (
	input  logic              clk,
	input  logic              arst_n,
	htok_in_if.sink           req,
	htok_out_if.source        tok
);

	htok_pkg::htok_res_t res;
	htok_pkg::htok_res_t res_q;
	logic                valid_q;
	logic                accept;

	// Take a new byte whenever the result register is empty or draining
	assign req.ready = !valid_q || tok.ready;
	assign accept    = req.valid && req.ready;

	htok_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (req.data_byte),
		.last_byte (req.last_byte),
		.res       (res)
	);

	// Result register: load on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (tok.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign tok.valid       = valid_q;
	assign tok.kind        = res_q.kind;
	assign tok.byte_out    = res_q.byte_out;
	assign tok.method_code = res_q.method_code;
	assign tok.error_code  = res_q.error_code;
	assign tok.request_end = res_q.request_end;

endmodule

>>> src/htok_fsm.sv
module htok_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output htok_pkg::htok_res_t res
);

	typedef enum logic [2:0] {
		PH_METHOD  = 3'd0,
		PH_URI     = 3'd1,
		PH_VERSION = 3'd2,
		PH_SKIPWS  = 3'd3,
		PH_HEADER  = 3'd4,
		PH_BODY    = 3'd5
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [55:0] mchars_q, mchars_n, app_chars;
	logic [3:0]  mcount_q, mcount_n, app_count;
	logic        colon_q, colon_n;
	logic        nonempty_q, nonempty_n;
	logic        skip_q, skip_n;
	logic [1:0]  err_q, err_n;
	logic [3:0]  lookup;
	logic        ws;
	logic        done;
	logic        do_hdr;

	// Append the byte to the method token, or mark it overlong
	always_comb begin
		app_chars = mchars_q;
		app_count = htok_pkg::METH_OVERLONG;
		if (mcount_q < 4'(htok_pkg::METH_MAX_LEN)) begin
			app_chars[8 * mcount_q[2:0] +: 8] = data_byte;
			app_count = mcount_q + 4'd1;
		end
	end

	assign ws     = htok_pkg::is_ws(data_byte);
	assign lookup = ws ? htok_pkg::meth_lookup(mchars_q, mcount_q)
		: htok_pkg::meth_lookup(app_chars, app_count);

	// Next state and result for the byte on the input
	always_comb begin
		phase_n    = phase_q;
		mchars_n   = mchars_q;
		mcount_n   = mcount_q;
		colon_n    = colon_q;
		nonempty_n = nonempty_q;
		skip_n     = skip_q;
		err_n      = err_q;
		done       = 1'b0;
		do_hdr     = 1'b0;
		res.kind        = htok_pkg::KIND_DROP;
		res.method_code = htok_pkg::METH_GET;
		if (err_q == htok_pkg::ERR_NONE) begin
			unique case (phase_q)
				PH_METHOD: begin
					if (ws) begin
						phase_n = PH_URI;
						done    = 1'b1;
					end else begin
						mchars_n = app_chars;
						mcount_n = app_count;
						done     = last_byte;
					end
					if (done) begin
						res.kind = htok_pkg::KIND_METHOD;
						if (lookup != htok_pkg::METH_UNKNOWN)
							res.method_code = lookup;
						else
							err_n = htok_pkg::ERR_METHOD;
					end
				end
				PH_URI: begin
					if (ws)
						phase_n = PH_VERSION;
					else
						res.kind = htok_pkg::KIND_URI;
				end
				PH_VERSION: begin
					if (ws)
						phase_n = PH_SKIPWS;
					else
						res.kind = htok_pkg::KIND_VERSION;
				end
				PH_SKIPWS: begin
					if (!ws) begin
						phase_n = PH_HEADER;
						do_hdr  = 1'b1;
					end
				end
				PH_HEADER: begin
					do_hdr = 1'b1;
				end
				PH_BODY: begin
					if (data_byte != htok_pkg::CH_CR && data_byte != htok_pkg::CH_LF)
						res.kind = htok_pkg::KIND_BODY;
				end
				default: begin
				end
			endcase

			// Header line: drop CR, close the line at LF, split at the first colon
			if (do_hdr) begin
				if (data_byte == htok_pkg::CH_CR) begin
					res.kind = htok_pkg::KIND_DROP;
				end else if (data_byte == htok_pkg::CH_LF) begin
					if (nonempty_q && !colon_q)
						err_n = htok_pkg::ERR_NO_COLON;
					else if (!nonempty_q)
						phase_n = PH_BODY;
					nonempty_n = 1'b0;
					colon_n    = 1'b0;
					skip_n     = 1'b0;
					res.kind   = htok_pkg::KIND_HDR_END;
				end else begin
					nonempty_n = 1'b1;
					if (!colon_q) begin
						if (data_byte == htok_pkg::CH_COLON) begin
							colon_n  = 1'b1;
							skip_n   = 1'b1;
							res.kind = htok_pkg::KIND_DROP;
						end else begin
							res.kind = htok_pkg::KIND_HDR_NAME;
						end
					end else if (skip_q) begin
						skip_n   = 1'b0;
						res.kind = htok_pkg::KIND_DROP;
					end else begin
						res.kind = htok_pkg::KIND_HDR_VAL;
					end
				end
			end

			// Request ends inside a header line that has no colon
			if (last_byte && phase_n == PH_HEADER && err_n == htok_pkg::ERR_NONE &&
				nonempty_n && !colon_n)
				err_n = htok_pkg::ERR_NO_COLON;
		end
		res.byte_out    = data_byte;
		res.error_code  = err_n;
		res.request_end = last_byte;
	end

	// Hold state; advance on each accepted request byte, clear after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_METHOD;
			mchars_q   <= '0;
			mcount_q   <= '0;
			colon_q    <= 1'b0;
			nonempty_q <= 1'b0;
			skip_q     <= 1'b0;
			err_q      <= htok_pkg::ERR_NONE;
		end else if (accept) begin
			if (last_byte) begin
				phase_q    <= PH_METHOD;
				mchars_q   <= '0;
				mcount_q   <= '0;
				colon_q    <= 1'b0;
				nonempty_q <= 1'b0;
				skip_q     <= 1'b0;
				err_q      <= htok_pkg::ERR_NONE;
			end else begin
				phase_q    <= phase_n;
				mchars_q   <= mchars_n;
				mcount_q   <= mcount_n;
				colon_q    <= colon_n;
				nonempty_q <= nonempty_n;
				skip_q     <= skip_n;
				err_q      <= err_n;
			end
		end
	end

endmodule

>>> src/htok_checker.sv
module htok_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] kind,
	input logic [3:0] method_code,
	input logic [1:0] error_code
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Every accepted request byte shows a result next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted byte produced no result");

	// An empty result register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// A method code only travels with a method result
	a_mcode_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != htok_pkg::KIND_METHOD |-> method_code == htok_pkg::METH_GET)
		else $error("method code outside method result");

	// With an error raised only drop, method, name or line end can appear
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != htok_pkg::ERR_NONE |->
		kind != htok_pkg::KIND_URI && kind != htok_pkg::KIND_VERSION &&
		kind != htok_pkg::KIND_HDR_VAL && kind != htok_pkg::KIND_BODY)
		else $error("byte passed on under an error");

endmodule

bind http_request_tokenizer_core htok_checker u_htok_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (tok.valid),
	.out_ready   (tok.ready),
	.kind        (tok.kind),
	.method_code (tok.method_code),
	.error_code  (tok.error_code)
);
